### rtl/core/ngwf_pkg.sv
package ngwf_pkg;
    localparam int Radius   = 2;
    localparam int Span     = 2 * Radius + 1;
    localparam int LineMax  = 1024;
    localparam int RingAw   = $clog2(Span * LineMax);
    localparam int RingSize = 1 << RingAw;
    localparam int IdxW     = 32;
    localparam int NumTaps  = Span * Span;
    localparam int QDepth   = 4;

    localparam logic [2:0] RegWidth  = 3'd0;
    localparam logic [2:0] RegHeight = 3'd1;

    typedef struct packed {
        logic [15:0] sample;
        logic        valid;
    } t_cell;

    typedef struct packed {
        logic [IdxW-1:0] base;
        logic [15:0]     orow;
        logic [10:0]     ocol;
        logic            last;
    } t_job;

    function automatic logic [2:0] dist_class(input int dy, input int dx);
        int d;
        begin
            d = dy * dy + dx * dx;
            case (d)
                0: dist_class = 3'd0;
                1: dist_class = 3'd1;
                2: dist_class = 3'd2;
                4: dist_class = 3'd3;
                5: dist_class = 3'd4;
                8: dist_class = 3'd5;
                default: dist_class = 3'd6;
            endcase
        end
    endfunction
endpackage

### rtl/core/normalized_gaussian_window_filter_top.sv
// A transfer that completes a centre cell's window queues one job; other transfers give
// no result. The back end takes one job at a time: it takes the job, makes 25 serial tap
// reads of the line store, runs the restoring divider and hands the result over, and takes
// no new job until the result is taken. Inputs are taken while the four-entry job queue
// has room. Reset (synchronous, active low) restores register defaults, clears the
// front-end and queue counters and idles the back end; the line store is not cleared.
module normalized_gaussian_window_filter_top import ngwf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // sample[15:0], sample_valid[16], zeros above
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // mean_value[15:0], is_nodata[16], zeros above
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [15:0] r_wt [6];
    logic [10:0] w_eff;
    logic [15:0] h_eff;
    logic        restart;
    logic        wr_en, jv, jr, qv, qr;
    logic [IdxW-1:0] wr_idx;
    t_cell       wr_cell;
    t_job        job, qjob;
    logic [15:0] mean;
    logic        nodata;

    assign w_eff = (r_width == '0) ? 11'd1 :
                   (r_width > 11'(LineMax)) ? 11'(LineMax) : r_width;
    assign h_eff = (r_height == '0) ? 16'd1 : r_height;
    assign restart = i_cfg_we && (i_cfg_idx == RegWidth || i_cfg_idx == RegHeight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 11'd1024;
            r_height <= 16'd1024;
            r_wt[0] <= 16'd65535;
            r_wt[1] <= 16'd39750;
            r_wt[2] <= 16'd24109;
            r_wt[3] <= 16'd8869;
            r_wt[4] <= 16'd5380;
            r_wt[5] <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegWidth:  r_width <= i_cfg_data[10:0];
                RegHeight: r_height <= i_cfg_data;
                default:   r_wt[i_cfg_idx - 3'd2] <= i_cfg_data;
            endcase
        end
    end

    ngwf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser),
        .i_cell({s_axis_tdata[15:0], s_axis_tdata[16]}),
        .i_w(w_eff), .i_h(h_eff), .i_restart(restart),
        .o_wr_en(wr_en), .o_wr_idx(wr_idx), .o_wr_cell(wr_cell),
        .o_job_valid(jv), .i_job_ready(jr), .o_job(job)
    );

    ngwf_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(jv), .o_ready(jr), .i_job(job),
        .o_valid(qv), .i_ready(qr), .o_job(qjob)
    );

    ngwf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_en(wr_en), .i_wr_idx(wr_idx), .i_wr_cell(wr_cell),
        .i_w(w_eff), .i_h(h_eff), .i_wt(r_wt),
        .i_job_valid(qv), .o_job_ready(qr), .i_job(qjob),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_mean(mean), .o_nodata(nodata), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, nodata, mean};
endmodule

### rtl/core/ngwf_front.sv
module ngwf_front import ngwf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_op,
    input  t_cell           i_cell,
    input  logic [10:0]     i_w,
    input  logic [15:0]     i_h,
    input  logic            i_restart,
    output logic            o_wr_en,
    output logic [IdxW-1:0] o_wr_idx,
    output t_cell           o_wr_cell,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output t_job            o_job
);
    logic [IdxW-1:0] r_iidx, n_iidx, r_oidx, n_oidx;
    logic [IdxW-1:0] r_base, n_base;
    logic [10:0]     r_ocol, n_ocol;
    logic [15:0]     r_orow, n_orow;
    logic [IdxW-1:0] total, delay, iidx_after;
    logic            write_ok, fire, emit;

    assign total = IdxW'(i_w) * IdxW'(i_h);
    assign delay = IdxW'(Radius) * IdxW'(i_w) + IdxW'(Radius);
    assign o_ready = i_job_ready;
    assign fire = i_valid && o_ready;
    assign write_ok = !i_op && (r_iidx < total);
    assign iidx_after = write_ok ? r_iidx + 1'b1 : r_iidx;
    assign emit = fire && (r_oidx < total) &&
                  ((iidx_after >= total) || (iidx_after > r_oidx + delay));
    assign o_wr_en = fire && write_ok;
    assign o_wr_idx = r_base + r_iidx;
    assign o_wr_cell = i_cell;
    assign o_job_valid = emit;
    assign o_job = '{base: r_base, orow: r_orow, ocol: r_ocol,
                     last: (r_oidx + 1'b1 == total)};

    always_comb begin
        n_iidx = r_iidx;
        n_oidx = r_oidx;
        n_ocol = r_ocol;
        n_orow = r_orow;
        n_base = r_base;
        if (fire) begin
            n_iidx = iidx_after;
        end
        if (emit) begin
            if (r_oidx + 1'b1 == total) begin
                n_iidx = '0;
                n_oidx = '0;
                n_ocol = '0;
                n_orow = '0;
                n_base = r_base + total;
            end else begin
                n_oidx = r_oidx + 1'b1;
                if (r_ocol + 1'b1 >= i_w) begin
                    n_ocol = '0;
                    n_orow = r_orow + 1'b1;
                end else begin
                    n_ocol = r_ocol + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_iidx <= '0;
            r_oidx <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_base <= '0;
        end else begin
            r_iidx <= n_iidx;
            r_oidx <= n_oidx;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
            r_base <= n_base;
        end
    end
endmodule

### rtl/core/ngwf_queue.sv
module ngwf_queue import ngwf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    localparam int Aw = $clog2(QDepth);
    t_job            r_mem [QDepth];
    logic [Aw-1:0]   r_wp, r_rp;
    logic [Aw:0]     r_cnt;
    logic            push, pop;

    assign o_ready = r_cnt != (Aw+1)'(QDepth);
    assign o_valid = r_cnt != '0;
    assign o_job = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Aw+1)'(push) - (Aw+1)'(pop);
        end
    end
endmodule

### rtl/core/ngwf_back.sv
module ngwf_back import ngwf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  logic [IdxW-1:0] i_wr_idx,
    input  t_cell           i_wr_cell,
    input  logic [10:0]     i_w,
    input  logic [15:0]     i_h,
    input  logic [15:0]     i_wt [6],
    input  logic            i_job_valid,
    output logic            o_job_ready,
    input  t_job            i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_mean,
    output logic            o_nodata,
    output logic            o_last
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TAP  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_cell              r_ring [RingSize];
    t_state             r_state;
    t_job               r_job;
    logic [4:0]         r_tap;
    logic               r_rd_ok, r_rd_act;
    logic [2:0]         r_rd_cls;
    logic               r_rd_centre;
    t_cell              r_rd;
    logic               r_cvalid;
    logic signed [39:0] r_sum;
    logic [20:0]        r_wsum;
    logic [39:0]        r_rem;
    logic [39:0]        r_quo;
    logic [5:0]         r_bit;
    logic               r_neg;
    logic [15:0]        r_mean;
    logic               r_nodata, r_last;

    logic signed [3:0]  dy, dx;
    logic signed [17:0] rr;
    logic signed [12:0] cc;
    logic               in_grid, taps_done;
    logic [IdxW-1:0]    lin;
    logic [RingAw-1:0]  raddr;
    logic [2:0]         cls;
    logic [15:0]        wt_c;
    logic [40:0]        trial;

    assign rr = $signed({2'b0, r_job.orow}) + 18'(dy);
    assign cc = $signed({2'b0, r_job.ocol}) + 13'(dx);
    assign in_grid = rr >= 0 && rr < $signed({2'b0, i_h}) &&
                     cc >= 0 && cc < $signed({2'b0, i_w});
    assign lin = r_job.base + IdxW'(rr[15:0]) * IdxW'(i_w) + IdxW'(cc[10:0]);
    assign raddr = RingAw'(lin % RingSize);
    always_comb begin
        cls = 3'd6;
        dy = '0;
        dx = '0;
        for (int k = 0; k < NumTaps; k++) begin
            if (r_tap == 5'(k)) begin
                cls = dist_class(k / Span - Radius, k % Span - Radius);
                dy = 4'(k / Span - Radius);
                dx = 4'(k % Span - Radius);
            end
        end
    end
    assign wt_c = (r_rd_cls == 3'd6) ? 16'd0 : i_wt[r_rd_cls];
    assign taps_done = r_tap == 5'(NumTaps);
    assign trial = {r_rem, r_quo[39]} - {20'd0, r_wsum};
    assign o_job_ready = r_state == S_IDLE;
    assign o_valid = r_state == S_OUT;
    assign o_mean = r_mean;
    assign o_nodata = r_nodata;
    assign o_last = r_last;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ring[RingAw'(i_wr_idx % RingSize)] <= i_wr_cell;
        end
        r_rd <= r_ring[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_act <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_rd_act <= 1'b0;
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_tap <= '0;
                        r_sum <= '0;
                        r_wsum <= '0;
                        r_cvalid <= 1'b0;
                        r_state <= S_TAP;
                    end
                end
                S_TAP: begin
                    r_rd_act <= !taps_done;
                    r_rd_ok <= in_grid;
                    r_rd_cls <= cls;
                    r_rd_centre <= r_tap == 5'(NumTaps / 2);
                    if (r_rd_act) begin
                        if (r_rd_centre) begin
                            r_cvalid <= r_rd.valid;
                        end
                        if (r_rd_ok && r_rd.valid && wt_c != 16'd0) begin
                            r_sum <= r_sum + 40'($signed({1'b0, wt_c}) *
                                                 $signed(r_rd.sample));
                            r_wsum <= r_wsum + 21'(wt_c);
                        end
                    end
                    if (!taps_done) begin
                        r_tap <= r_tap + 1'b1;
                    end else if (!r_rd_act) begin
                        r_neg <= r_sum[39];
                        r_quo <= r_sum[39] ? 40'(-r_sum) : 40'(r_sum);
                        r_rem <= '0;
                        r_bit <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (trial[40]) begin
                        r_rem <= {r_rem[38:0], r_quo[39]};
                        r_quo <= {r_quo[38:0], 1'b0};
                    end else begin
                        r_rem <= trial[39:0];
                        r_quo <= {r_quo[38:0], 1'b1};
                    end
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 6'd40) begin
                        r_nodata <= !r_cvalid || r_wsum == '0;
                        r_mean <= (!r_cvalid || r_wsum == '0) ? 16'd0 :
                                  (r_neg ? 16'(-r_quo[15:0]) : r_quo[15:0]);
                        r_last <= r_job.last;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### dv/tb_top.sv
module tb_top;
    import ngwf_pkg::*;

    localparam bit         OP_CELL  = 1'b0;
    localparam bit         OP_FLUSH = 1'b1;
    localparam logic [2:0] REG_WT0  = 3'd2;
    localparam int         RING     = 5 * 1024;
    localparam int         STALL_LIMIT = 5000;
    localparam int         SETTLE   = 400;

    typedef struct packed {
        logic [15:0] mean;
        logic        nodata;
        logic        last;
    } t_mean;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  idx;
        logic        op;
        logic [15:0] smp;
        logic        vld;
        logic        known;
        t_mean       res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    normalized_gaussian_window_filter_top DUT (.*);

    always #10 i_clk = ~i_clk;

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [15:0] tap_wt [6];
    logic [16:0] ring_cells [RING];
    int unsigned in_col, in_row, out_col, out_row;

    t_mean pending_means [$];
    int    errors, n_cells, n_flushes, n_results, n_nodata, idle_cycles;
    bit    burst, hold_req;

    function automatic logic [15:0] weight_for(int d);
        case (d)
            0: return tap_wt[0];
            1: return tap_wt[1];
            2: return tap_wt[2];
            4: return tap_wt[3];
            5: return tap_wt[4];
            8: return tap_wt[5];
            default: return 16'd0;
        endcase
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > 1024) return 1024;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic bit filter_step(input bit op, input logic [15:0] smp, input bit vld,
                                       output t_mean r);
        int unsigned w, h, total, delay, iidx, oidx;
        longint      acc, wsum, q;
        int          rr, cc, dy, dx;
        logic [15:0] wt;
        logic [16:0] e;
        w = eff_width();
        h = eff_height();
        total = w * h;
        delay = 2 * w + 2;
        iidx = in_row * w + in_col;
        r = '0;
        if (op == OP_CELL && iidx < total) begin
            ring_cells[iidx % RING] = {vld, smp};
            iidx++;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        oidx = out_row * w + out_col;
        if (oidx >= total) return 0;
        if (!(iidx >= total || iidx > oidx + delay)) return 0;
        acc = 0;
        wsum = 0;
        r.nodata = 1'b1;
        if (ring_cells[oidx % RING][16]) begin
            for (dy = -2; dy <= 2; dy++) begin
                rr = int'(out_row) + dy;
                if (rr < 0 || rr >= int'(h)) continue;
                for (dx = -2; dx <= 2; dx++) begin
                    cc = int'(out_col) + dx;
                    if (cc < 0 || cc >= int'(w)) continue;
                    wt = weight_for(dx * dx + dy * dy);
                    if (wt == 0) continue;
                    e = ring_cells[(rr * w + cc) % RING];
                    if (!e[16]) continue;
                    acc += longint'(wt) * longint'($signed(e[15:0]));
                    wsum += longint'(wt);
                end
            end
            if (wsum > 0) begin
                q = acc / wsum;
                r.mean = q[15:0];
                r.nodata = 1'b0;
            end
        end
        r.last = (oidx + 1 == total);
        if (r.last) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    function automatic bit frame_open();
        return (in_col | in_row | out_col | out_row) != 0;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            RegWidth: width_reg = val[10:0];
            RegHeight: height_reg = val;
            default: tap_wt[idx - REG_WT0] = val;
        endcase
        if (idx == RegWidth || idx == RegHeight) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end
    endtask

    task automatic wait_idle();
        i_cfg_we <= 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input int w, input int h, input logic [15:0] wts [6]);
        wait_idle();
        write_reg(RegWidth, w[15:0]);
        write_reg(RegHeight, h[15:0]);
        for (int k = 0; k < 6; k++) write_reg(REG_WT0 + 3'(k), wts[k]);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input bit op, input logic [15:0] smp, input bit vld,
                             input bit known, input t_mean given);
        int    gap;
        t_mean r;
        i_cfg_we <= 1'b0;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, vld, smp};
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == OP_CELL) n_cells++;
        else n_flushes++;
        if (filter_step(op, smp, vld, r)) pending_means.push_back(known ? given : r);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic stream_frames(input int max_items);
        int          sent, total;
        bit          cut;
        logic [15:0] smp;
        sent = 0;
        while (sent < max_items) begin
            burst = ($urandom_range(0, 3) == 0);
            total = eff_width() * eff_height();
            cut = 1'b0;
            for (int k = 0; k < total; k++) begin
                if (sent >= max_items) begin
                    cut = 1'b1;
                    break;
                end
                if ($urandom_range(0, 19) == 0) begin
                    send_item(OP_FLUSH, 16'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
                    sent++;
                end
                smp = rand_sample();
                send_item(OP_CELL, smp, $urandom_range(0, 7) != 0, 1'b0, '0);
                sent++;
            end
            if (cut) break;
            while (frame_open()) begin
                send_item($urandom_range(0, 9) == 0 ? OP_CELL : OP_FLUSH, rand_sample(),
                          1'($urandom_range(0, 1)), 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                send_item(OP_FLUSH, 16'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
                sent++;
            end
        end
        burst = 1'b0;
    endtask

    // Receiver: random back-pressure, one long hold on request, and the result check.
    initial begin
        int    gap;
        t_mean got, exp_r;
        @(posedge i_rst_n);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 19);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end else if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.mean = m_axis_tdata[15:0];
            got.nodata = m_axis_tdata[16];
            got.last = m_axis_tlast;
            n_results++;
            if (got.nodata) n_nodata++;
            if (pending_means.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: mean %0d nodata %0b last %0b",
                             $signed(got.mean), got.nodata, got.last);
            end else begin
                exp_r = pending_means.pop_front();
                if (got != exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected mean %0d nodata %0b last %0b, got %0d %0b %0b",
                                 $signed(exp_r.mean), exp_r.nodata, exp_r.last,
                                 $signed(got.mean), got.nodata, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    t_row directed [] = '{
        '{1'b1, RegWidth,  OP_CELL,  16'd1,    1'b0, 1'b0, '0},
        '{1'b1, RegHeight, OP_CELL,  16'd1,    1'b0, 1'b0, '0},
        '{1'b0, 3'd0,      OP_CELL,  16'h7FFF, 1'b1, 1'b1, '{16'h7FFF, 1'b0, 1'b1}},
        '{1'b0, 3'd0,      OP_CELL,  16'h8000, 1'b1, 1'b1, '{16'h8000, 1'b0, 1'b1}},
        '{1'b0, 3'd0,      OP_CELL,  16'h1234, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b1}},
        '{1'b0, 3'd0,      OP_FLUSH, 16'hFFFF, 1'b1, 1'b0, '0},
        '{1'b1, REG_WT0,   OP_CELL,  16'd0,    1'b0, 1'b0, '0},
        '{1'b0, 3'd0,      OP_CELL,  16'd5,    1'b1, 1'b1, '{16'h0000, 1'b1, 1'b1}},
        '{1'b1, REG_WT0,   OP_CELL,  16'hFFFF, 1'b0, 1'b0, '0},
        '{1'b1, RegWidth,  OP_CELL,  16'd3,    1'b0, 1'b0, '0},
        '{1'b1, RegHeight, OP_CELL,  16'd2,    1'b0, 1'b0, '0},
        '{1'b0, 3'd0,      OP_CELL,  16'h7FFF, 1'b1, 1'b0, '0},
        '{1'b0, 3'd0,      OP_CELL,  16'h8000, 1'b1, 1'b0, '0},
        '{1'b0, 3'd0,      OP_CELL,  16'h0001, 1'b0, 1'b0, '0},
        '{1'b0, 3'd0,      OP_FLUSH, 16'h0000, 1'b0, 1'b0, '0},
        '{1'b0, 3'd0,      OP_CELL,  16'hFFFF, 1'b1, 1'b0, '0},
        '{1'b0, 3'd0,      OP_CELL,  16'h0000, 1'b1, 1'b0, '0},
        '{1'b0, 3'd0,      OP_CELL,  16'h7FFF, 1'b1, 1'b0, '0},
        '{1'b0, 3'd0,      OP_CELL,  16'h5555, 1'b1, 1'b0, '0},
        '{1'b0, 3'd0,      OP_FLUSH, 16'h0000, 1'b0, 1'b0, '0},
        '{1'b0, 3'd0,      OP_FLUSH, 16'h0000, 1'b0, 1'b0, '0},
        '{1'b0, 3'd0,      OP_FLUSH, 16'h0000, 1'b0, 1'b0, '0},
        '{1'b0, 3'd0,      OP_FLUSH, 16'h0000, 1'b0, 1'b0, '0},
        '{1'b0, 3'd0,      OP_FLUSH, 16'hAAAA, 1'b1, 1'b0, '0}
    };

    initial begin
        logic [15:0] wts [6];
        bit          after_item;
        width_reg = 11'd1024;
        height_reg = 16'd1024;
        tap_wt = '{16'd65535, 16'd39750, 16'd24109, 16'd8869, 16'd5380, 16'd0};
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        after_item = 1'b0;
        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                if (after_item) wait_idle();
                write_reg(directed[i].idx, directed[i].smp);
                after_item = 1'b0;
            end else begin
                send_item(directed[i].op, directed[i].smp, directed[i].vld,
                          directed[i].known, directed[i].res);
                after_item = 1'b1;
            end
        end

        wts = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        configure(2047, 1, wts);
        stream_frames(1);

        for (int k = 0; k < 6; k++) wts[k] = 16'($urandom);
        configure(0, 0, wts);
        stream_frames(40);

        wts = '{16'd65535, 16'd39750, 16'd24109, 16'd8869, 16'd5380, 16'd0};
        configure(7, 5, wts);
        hold_req = 1'b1;
        stream_frames(150);

        for (int k = 0; k < 6; k++) wts[k] = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        configure(4, 65535, wts);
        stream_frames(120);

        wts = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        configure(1, 9, wts);
        stream_frames(30);

        for (int p = 0; p < 6; p++) begin
            for (int k = 0; k < 6; k++) wts[k] = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
            configure($urandom_range(1, 12), $urandom_range(1, 6), wts);
            stream_frames(60);
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (pending_means.size() != 0) @(posedge i_clk);
            stream_frames(50);
        end

        wait_idle();
        if (pending_means.size() != 0) errors += pending_means.size();
        $display("covered %0d cells and %0d flushes over many grid shapes and weight sets",
                 n_cells, n_flushes);
        $display("received %0d results, %0d of them nodata; %0d errors",
                 n_results, n_nodata, errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### sim.f
rtl/core/ngwf_pkg.sv
rtl/core/ngwf_front.sv
rtl/core/ngwf_queue.sv
rtl/core/ngwf_back.sv
rtl/core/normalized_gaussian_window_filter_top.sv
dv/tb_top.sv
